FILE: sv/tcw_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helpers for the text console writer
// no dependencies

package tcw_pkg;

    localparam int COLS      = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CNT_W     = $clog2(CELLS + 1);
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
    localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'h1F;
    localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h07;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEXT_ATTR  = 1'b0,
        REG_BLANK_ATTR = 1'b1
    } reg_idx_t;

    // one write port and one read port per cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c));
    endfunction

endpackage

FILE: sv/tcw_cell_mem.sv
`timescale 1ns / 1ps
// cell store: one write port, one read port with registered read data
// depends on tcw_pkg

module tcw_cell_mem
(
    input  logic                        clk,
    input  tcw_pkg::mem_req_t           req,
    output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

FILE: sv/text_console_writer.sv
`timescale 1ns / 1ps
// text console writer top level: command decode, cursor, scroll and blank sweeps
// depends on tcw_pkg and tcw_cell_mem

// A request is taken when start is high and busy is low; its result shows on the
// result ports for one cycle with done high, and must be captured then. Set cursor,
// an out-of-range read and a put that does not scroll answer in the cycle after the
// request; a read first passes through the read state, waiting on the cell store's
// registered read. Clear blanks the store one cell per cycle through its single
// write port and answers once the last cell is written. A put on the last cell of
// the screen writes the cell, then copies every row up one cell per cycle, each
// write following its registered read, then blanks the bottom row before it
// answers. busy is high for the whole of a read, clear or scroll. Configuration
// writes are always ready and are registered; they also act on a sweep under way.

module text_console_writer
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      operation,
    input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  logic [tcw_pkg::COL_W-1:0]       column,
    input  logic [tcw_pkg::ROW_W-1:0]       row,
    output logic                            done,
    output logic [tcw_pkg::COL_W-1:0]       cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]       cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0]      cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]      cell_attr,
    output logic                            scrolled,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_SCROLL = 4'b0100,
        ST_BLANK  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [tcw_pkg::COL_W-1:0]       cur_col_reg, cur_col_next;
    logic [tcw_pkg::ROW_W-1:0]       cur_row_reg, cur_row_next;
    logic [tcw_pkg::ATTR_W-1:0]      text_attr_reg;
    logic [tcw_pkg::ATTR_W-1:0]      blank_attr_reg;
    logic [tcw_pkg::CNT_W-1:0]       src_reg, src_next;
    logic [tcw_pkg::ADDR_W-1:0]      dst_reg, dst_next;
    logic                            pend_reg, pend_next;
    logic [tcw_pkg::ADDR_W-1:0]      blank_reg, blank_next;
    logic                            scroll_flag_reg, scroll_flag_next;
    logic                            done_reg, done_next;
    logic [tcw_pkg::CHAR_W-1:0]      cell_char_reg, cell_char_next;
    logic [tcw_pkg::ATTR_W-1:0]      cell_attr_reg, cell_attr_next;
    logic                            scrolled_reg, scrolled_next;

    tcw_pkg::mem_req_t               mem_req;
    logic [tcw_pkg::CELL_W-1:0]      rd_data;
    logic                            col_ok;
    logic                            row_ok;
    logic                            issue;

    tcw_cell_mem u_cell_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign cursor_col = cur_col_reg;
    assign cursor_row = cur_row_reg;
    assign cell_char  = cell_char_reg;
    assign cell_attr  = cell_attr_reg;
    assign scrolled   = scrolled_reg;

    assign col_ok = (32'(column) < tcw_pkg::COLS);
    assign row_ok = (32'(row) < tcw_pkg::ROWS);
    assign issue  = (src_reg != tcw_pkg::CNT_W'(tcw_pkg::CELLS));

    always_comb
    begin
        state_next       = state_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        pend_next        = 1'b0;
        blank_next       = blank_reg;
        scroll_flag_next = scroll_flag_reg;
        done_next        = 1'b0;
        cell_char_next   = '0;
        cell_attr_next   = '0;
        scrolled_next    = 1'b0;
        mem_req          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (tcw_pkg::op_t'(operation))
                        tcw_pkg::OP_PUT:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = tcw_pkg::cell_addr(cur_row_reg, cur_col_reg);
                            mem_req.wdata = {text_attr_reg, char_code};
                            if (cur_col_reg == tcw_pkg::COL_W'(tcw_pkg::COLS - 1))
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1))
                                begin
                                    // last cell: move rows up, then blank the bottom row
                                    state_next       = ST_SCROLL;
                                    src_next         = tcw_pkg::CNT_W'(tcw_pkg::COLS);
                                    dst_next         = '0;
                                    scroll_flag_next = 1'b1;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                    done_next    = 1'b1;
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                                done_next    = 1'b1;
                            end
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            state_next       = ST_BLANK;
                            blank_next       = '0;
                            cur_col_next     = '0;
                            cur_row_next     = '0;
                            scroll_flag_next = 1'b0;
                        end
                        tcw_pkg::OP_SET:
                        begin
                            if (col_ok)
                            begin
                                cur_col_next = column;
                            end
                            if (row_ok)
                            begin
                                cur_row_next = row;
                            end
                            done_next = 1'b1;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            if (col_ok && row_ok)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = tcw_pkg::cell_addr(row, column);
                                state_next    = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cell_char_next = rd_data[tcw_pkg::CHAR_W-1:0];
                cell_attr_next = rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_SCROLL:
            begin
                // each cell is read one row below its destination; the write follows its registered read
                if (issue)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = src_reg[tcw_pkg::ADDR_W-1:0];
                    src_next      = src_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = dst_reg;
                    mem_req.wdata = rd_data;
                    dst_next      = dst_reg + 1'b1;
                end
                pend_next = issue;
                if (!issue)
                begin
                    state_next = ST_BLANK;
                    blank_next = tcw_pkg::ADDR_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLS);
                end
            end
            ST_BLANK:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = blank_reg;
                mem_req.wdata = {blank_attr_reg, tcw_pkg::BLANK_CHAR};
                if (blank_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    state_next    = ST_IDLE;
                    done_next     = 1'b1;
                    scrolled_next = scroll_flag_reg;
                end
                else
                begin
                    blank_next = blank_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            pend_reg        <= 1'b0;
            scroll_flag_reg <= 1'b0;
            done_reg        <= 1'b0;
            scrolled_reg    <= 1'b0;
            cell_char_reg   <= '0;
            cell_attr_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            pend_reg        <= pend_next;
            scroll_flag_reg <= scroll_flag_next;
            done_reg        <= done_next;
            scrolled_reg    <= scrolled_next;
            cell_char_reg   <= cell_char_next;
            cell_attr_reg   <= cell_attr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        blank_reg <= blank_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg  <= tcw_pkg::TEXT_ATTR_RST;
            blank_attr_reg <= tcw_pkg::BLANK_ATTR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tcw_pkg::reg_idx_t'(cfg_index))
                tcw_pkg::REG_TEXT_ATTR:  text_attr_reg  <= cfg_data;
                tcw_pkg::REG_BLANK_ATTR: blank_attr_reg <= cfg_data;
            endcase
        end
    end

    a_cursor_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_col_reg) < tcw_pkg::COLS)
        else $error("cursor column out of range");

    a_cursor_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_row_reg) < tcw_pkg::ROWS)
        else $error("cursor row out of range");

    a_idle_write_is_put: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && mem_req.we |-> start && (operation == tcw_pkg::OP_PUT))
        else $error("cell store written while idle without a put request");

    a_scroll_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL) && pend_reg |->
            (tcw_pkg::CNT_W'(dst_reg) + tcw_pkg::CNT_W'(tcw_pkg::COLS) < src_reg))
        else $error("scroll write overtook its read");

    a_scrolled_home: assert property (@(posedge clk) disable iff (!rst_n)
        scrolled |-> done && (cursor_col == '0)
            && (cursor_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)))
        else $error("scroll result with cursor not at start of last row");

endmodule

FILE: dv/text_console_writer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for text_console_writer: directed and random requests
// with a screen scoreboard that predicts every result; depends on tcw_pkg and the rtl

class console_scoreboard;

    typedef struct {
        logic [tcw_pkg::COL_W-1:0]  col;
        logic [tcw_pkg::ROW_W-1:0]  row;
        logic [tcw_pkg::CHAR_W-1:0] ch;
        logic [tcw_pkg::ATTR_W-1:0] attr;
        logic                       scr;
    } screen_answer_t;

    logic [tcw_pkg::CELL_W-1:0] cells [tcw_pkg::CELLS];
    bit                         known [tcw_pkg::CELLS];
    bit [tcw_pkg::COL_W-1:0]    cur_col;
    bit [tcw_pkg::ROW_W-1:0]    cur_row;
    bit [tcw_pkg::ATTR_W-1:0]   text_attr;
    bit [tcw_pkg::ATTR_W-1:0]   blank_attr;
    screen_answer_t             answer_q[$];
    int                         errors;

    function new();
        foreach (cells[i])
        begin
            cells[i] = '0;
            known[i] = 1'b0;
        end
        cur_col    = '0;
        cur_row    = '0;
        text_attr  = tcw_pkg::TEXT_ATTR_RST;
        blank_attr = tcw_pkg::BLANK_ATTR_RST;
        errors     = 0;
    endfunction

    function void set_reg(tcw_pkg::reg_idx_t idx, logic [7:0] val);
        if (idx == tcw_pkg::REG_TEXT_ATTR)
            text_attr = val;
        else
            blank_attr = val;
    endfunction

    function bit put_scrolls();
        return cur_col == tcw_pkg::COLS - 1 && cur_row == tcw_pkg::ROWS - 1;
    endfunction

    function bit cell_known(logic [6:0] col, logic [4:0] row);
        if (col >= tcw_pkg::COLS || row >= tcw_pkg::ROWS)
            return 1'b0;
        return known[int'(row) * tcw_pkg::COLS + int'(col)];
    endfunction

    function int pending();
        return answer_q.size();
    endfunction

    function void note_request(tcw_pkg::op_t op, logic [7:0] ch, logic [6:0] col,
                               logic [4:0] row);
        screen_answer_t ans;
        int             idx;
        ans = '{col: '0, row: '0, ch: '0, attr: '0, scr: 1'b0};
        case (op)
            tcw_pkg::OP_PUT:
            begin
                idx        = int'(cur_row) * tcw_pkg::COLS + int'(cur_col);
                cells[idx] = {text_attr, ch};
                known[idx] = 1'b1;
                if (cur_col < tcw_pkg::COLS - 1)
                    cur_col++;
                else
                begin
                    cur_col = '0;
                    if (cur_row == tcw_pkg::ROWS - 1)
                    begin
                        // every row moves up, bottom row blanked
                        for (int i = 0; i < (tcw_pkg::ROWS - 1) * tcw_pkg::COLS; i++)
                        begin
                            cells[i] = cells[i + tcw_pkg::COLS];
                            known[i] = known[i + tcw_pkg::COLS];
                        end
                        for (int i = (tcw_pkg::ROWS - 1) * tcw_pkg::COLS;
                             i < tcw_pkg::CELLS; i++)
                        begin
                            cells[i] = {blank_attr, tcw_pkg::BLANK_CHAR};
                            known[i] = 1'b1;
                        end
                        ans.scr = 1'b1;
                    end
                    else
                        cur_row++;
                end
            end
            tcw_pkg::OP_CLEAR:
            begin
                foreach (cells[i])
                begin
                    cells[i] = {blank_attr, tcw_pkg::BLANK_CHAR};
                    known[i] = 1'b1;
                end
                cur_col = '0;
                cur_row = '0;
            end
            tcw_pkg::OP_SET:
            begin
                if (col < tcw_pkg::COLS)
                    cur_col = col;
                if (row < tcw_pkg::ROWS)
                    cur_row = row;
            end
            default:
            begin
                if (col < tcw_pkg::COLS && row < tcw_pkg::ROWS)
                begin
                    idx      = int'(row) * tcw_pkg::COLS + int'(col);
                    ans.ch   = cells[idx][7:0];
                    ans.attr = cells[idx][15:8];
                end
            end
        endcase
        ans.col = cur_col;
        ans.row = cur_row;
        answer_q.push_back(ans);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("ERROR %0t: %s got 'h%0h want 'h%0h", $time, what, got, want);
    endtask

    task check_result(logic [6:0] col, logic [4:0] row, logic [7:0] ch, logic [7:0] attr,
                      logic scr);
        screen_answer_t want;
        if (answer_q.size() == 0)
        begin
            report("result with no request outstanding", {9'd0, col}, '0);
            return;
        end
        want = answer_q.pop_front();
        if (col !== want.col)
            report("cursor_col", 16'(col), 16'(want.col));
        if (row !== want.row)
            report("cursor_row", 16'(row), 16'(want.row));
        if (ch !== want.ch)
            report("cell_char", 16'(ch), 16'(want.ch));
        if (attr !== want.attr)
            report("cell_attr", 16'(attr), 16'(want.attr));
        if (scr !== want.scr)
            report("scrolled", 16'(scr), 16'(want.scr));
    endtask

endclass

module text_console_writer_tb;

    localparam int N_RANDOM       = 1052;
    localparam int PHASES         = 4;
    localparam int MAX_GAP        = 40;
    localparam int MAX_LONG_OPS   = 120;
    localparam int LONG_OP_CYCLES = tcw_pkg::CELLS + 2;
    localparam int CYCLE_LIMIT    = 4 * ((N_RANDOM + 64) * (MAX_GAP + 4)
                                         + (MAX_LONG_OPS + 8) * LONG_OP_CYCLES);

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          start     = 1'b0;
    logic                          busy;
    logic [1:0]                    operation = tcw_pkg::OP_PUT;
    logic [tcw_pkg::CHAR_W-1:0]    char_code = '0;
    logic [tcw_pkg::COL_W-1:0]     column    = '0;
    logic [tcw_pkg::ROW_W-1:0]     row       = '0;
    logic                          done;
    logic [tcw_pkg::COL_W-1:0]     cursor_col;
    logic [tcw_pkg::ROW_W-1:0]     cursor_row;
    logic [tcw_pkg::CHAR_W-1:0]    cell_char;
    logic [tcw_pkg::ATTR_W-1:0]    cell_attr;
    logic                          scrolled;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index = tcw_pkg::REG_TEXT_ATTR;
    logic [7:0]                    cfg_data  = '0;

    console_scoreboard sb = new();
    int                cycle_count = 0;
    int                long_ops    = 0;

    text_console_writer u_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(cursor_col, cursor_row, cell_char, cell_attr, scrolled);

    // leaves start high so back-to-back requests need no second assignment
    task automatic send_request(tcw_pkg::op_t op, logic [7:0] ch, logic [6:0] col,
                                logic [4:0] r);
        start     <= 1'b1;
        operation <= op;
        char_code <= ch;
        column    <= col;
        row       <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(op, ch, col, r);
    endtask

    task automatic idle_sender(bit burst);
        int n;
        int pick;
        if (burst)
            return;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            n = 0;
        else if (pick < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, MAX_GAP);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0 || busy);
    endtask

    task automatic write_config(logic [7:0] text_val, logic [7:0] blank_val);
        cfg_valid <= 1'b1;
        cfg_index <= tcw_pkg::REG_TEXT_ATTR;
        cfg_data  <= text_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(tcw_pkg::REG_TEXT_ATTR, text_val);
        cfg_index <= tcw_pkg::REG_BLANK_ATTR;
        cfg_data  <= blank_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(tcw_pkg::REG_BLANK_ATTR, blank_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int           pick;
        tcw_pkg::op_t op;
        logic [7:0]   ch;
        logic [6:0]   col;
        logic [4:0]   r;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        col  = 7'($urandom_range(0, 127));
        r    = 5'($urandom_range(0, 31));
        if (pick < 45)
            op = tcw_pkg::OP_PUT;
        else if (pick < 65)
            op = tcw_pkg::OP_SET;
        else if (pick < 97)
            op = tcw_pkg::OP_READ;
        else
            op = tcw_pkg::OP_CLEAR;
        // clear and scroll sweep the whole store, keep their number bounded
        if (op == tcw_pkg::OP_CLEAR || (op == tcw_pkg::OP_PUT && sb.put_scrolls()))
        begin
            if (long_ops >= MAX_LONG_OPS)
                op = tcw_pkg::OP_SET;
            else
                long_ops++;
        end
        pick = $urandom_range(0, 99);
        if (op == tcw_pkg::OP_SET)
        begin
            if (pick < 25)
            begin
                col = 7'(tcw_pkg::COLS - 1 - $urandom_range(0, 9));
                r   = 5'(tcw_pkg::ROWS - 1);
            end
            else if (pick < 80)
            begin
                col = 7'($urandom_range(0, tcw_pkg::COLS - 1));
                r   = 5'($urandom_range(0, tcw_pkg::ROWS - 1));
            end
        end
        else if (op == tcw_pkg::OP_READ)
        begin
            if (pick < 75)
            begin
                col = 7'($urandom_range(0, tcw_pkg::COLS - 1));
                r   = 5'($urandom_range(0, tcw_pkg::ROWS - 1));
            end
            // never address a cell that holds nothing yet
            if (col < tcw_pkg::COLS && r < tcw_pkg::ROWS && !sb.cell_known(col, r))
                col = 7'(tcw_pkg::COLS + $urandom_range(0, 127 - tcw_pkg::COLS));
        end
        send_request(op, ch, col, r);
    endtask

    initial
    begin
        bit burst;
        burst = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset attributes, edges of every field, wrap and scroll
        send_request(tcw_pkg::OP_PUT,   8'h00, 7'd0,   5'd0);
        send_request(tcw_pkg::OP_PUT,   8'hFF, 7'd127, 5'd31);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd0,   5'd0);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd1,   5'd0);
        send_request(tcw_pkg::OP_READ,  8'hFF, 7'd127, 5'd31);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd80,  5'd0);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd0,   5'd25);
        send_request(tcw_pkg::OP_SET,   8'h00, 7'd127, 5'd31);
        send_request(tcw_pkg::OP_SET,   8'h00, 7'd79,  5'd31);
        send_request(tcw_pkg::OP_SET,   8'h00, 7'd100, 5'd24);
        send_request(tcw_pkg::OP_PUT,   8'h41, 7'd0,   5'd0);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd79,  5'd23);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd0,   5'd24);
        send_request(tcw_pkg::OP_CLEAR, 8'hA5, 7'd127, 5'd31);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd79,  5'd24);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd0,   5'd0);
        send_request(tcw_pkg::OP_SET,   8'h00, 7'd78,  5'd24);
        send_request(tcw_pkg::OP_PUT,   8'h41, 7'd0,   5'd0);
        send_request(tcw_pkg::OP_PUT,   8'h7E, 7'd0,   5'd0);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd78,  5'd23);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd79,  5'd23);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd0,   5'd24);
        send_request(tcw_pkg::OP_SET,   8'h00, 7'd0,   5'd0);
        send_request(tcw_pkg::OP_PUT,   8'h80, 7'd0,   5'd0);
        send_request(tcw_pkg::OP_READ,  8'h00, 7'd0,   5'd0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       write_config(8'h00, 8'hFF);
                1:       write_config(8'hFF, 8'h00);
                2:       write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: write_config(8'hA5, 8'h5A);
            endcase
            for (int i = 0; i < N_RANDOM / PHASES; i++)
            begin
                if (i % 64 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                random_request();
                if ($urandom_range(0, 99) == 0)
                begin
                    // hold off until the block has answered everything
                    start <= 1'b0;
                    do
                        @(posedge clk);
                    while (sb.pending() != 0);
                end
                else
                    idle_sender(burst);
            end
            drain();
        end

        repeat (16) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
